// ----- sv/bdrt_pkg.sv -----
// -----------------------------------------------------------------------------
// Button debounce and relay toggle package
// Shared widths, reset values, register indexes and beat types.
// -----------------------------------------------------------------------------
package bdrt_pkg;

	// Fixed field widths.
	localparam int BTN_W     = 8;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 4;

	// Default number of button lanes.
	localparam int NUM_BUTTONS_DEF = 8;

	// Register reset values.
	localparam logic [CNT_W-1:0] THRESHOLD_RST  = CNT_W'(3);
	localparam logic             ACTIVE_LOW_RST = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD  = 1'b0,
		CFG_ACTIVE_LOW = 1'b1
	} cfg_reg_t;

	// One input beat.
	typedef struct packed {
		logic [BTN_W-1:0] buttons_raw;
		logic             read_ok;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic [BTN_W-1:0] stable_buttons;
		logic [BTN_W-1:0] relay_out;
		logic [BTN_W-1:0] toggled_relays;
		logic             report_changed;
		logic             read_error;
	} out_beat_t;

	// Control shared by every lane for the current beat.
	typedef struct packed {
		logic             update;
		logic [CNT_W-1:0] threshold;
		logic             active_low;
	} lane_ctrl_t;

	// Number of lanes that can see a port bit.
	function automatic int lane_count(input int num_buttons);
		lane_count = (num_buttons < BTN_W) ? num_buttons : BTN_W;
	endfunction

endpackage

// ----- sv/bdrt_lane.sv -----
// -----------------------------------------------------------------------------
// Debounce lane
// Per-button counter that decides when the stable bit flips and whether
// the flip is a press that toggles the relay.
// -----------------------------------------------------------------------------
module bdrt_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  bdrt_pkg::lane_ctrl_t ctrl,
	input  logic                raw_bit,
	input  logic                stable_bit,
	output logic                flip,
	output logic                toggle
);
	import bdrt_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W:0]   count_inc;
	logic             differ;

	// The next count is one wider so the threshold compare never wraps.
	assign count_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
	assign differ    = raw_bit ^ stable_bit;
	assign flip      = ctrl.update & differ & (count_inc >= {1'b0, ctrl.threshold});

	// After a flip the stable bit equals the raw bit, so the press test uses it.
	assign toggle = flip & (raw_bit ^ ctrl.active_low);

	// On an update the counter clears on agreement or on a flip, else counts up; otherwise it holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.update) begin
			if (!differ || flip) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc[CNT_W-1:0];
			end
		end
	end

endmodule

// ----- sv/bdrt_merge.sv -----
// -----------------------------------------------------------------------------
// Debounce merge stage
// Holds the debounced, reported and relay masks, folds in the flips and
// toggles found by the lanes and forms the result beat.
// -----------------------------------------------------------------------------
module bdrt_merge #(
	parameter int NUM_BUTTONS = bdrt_pkg::NUM_BUTTONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  bdrt_pkg::in_beat_t            in_beat,
	input  logic [bdrt_pkg::BTN_W-1:0]    flips,
	input  logic [bdrt_pkg::BTN_W-1:0]    toggles,
	output logic                          lanes_run,
	output logic [bdrt_pkg::BTN_W-1:0]    raw_masked,
	output logic [bdrt_pkg::BTN_W-1:0]    stable_mask,
	output bdrt_pkg::out_beat_t           result
);
	import bdrt_pkg::*;

	localparam int LANES = lane_count(NUM_BUTTONS);
	localparam logic [BTN_W-1:0] LANE_MASK = BTN_W'((64'd1 << LANES) - 64'd1);

	logic [BTN_W-1:0] debounced_q;
	logic [BTN_W-1:0] reported_q;
	logic [BTN_W-1:0] relay_q;
	logic             snapshot_q;

	logic             good;
	logic             first;
	logic [BTN_W-1:0] deb_next;
	logic [BTN_W-1:0] relay_next;
	logic             report;

	// Classify the beat: failed read, first good sample, or normal update.
	assign raw_masked  = in_beat.buttons_raw & LANE_MASK;
	assign good        = accept & in_beat.read_ok;
	assign first       = good & ~snapshot_q;
	assign lanes_run   = good & snapshot_q;
	assign stable_mask = debounced_q;

	// Next masks and the change report.
	always_comb begin
		deb_next   = debounced_q;
		relay_next = relay_q;
		if (first) begin
			deb_next = raw_masked;
		end else if (lanes_run) begin
			deb_next   = debounced_q ^ flips;
			relay_next = relay_q ^ toggles;
		end
		report = lanes_run & (|flips) & (deb_next != reported_q);
	end

	// Result beat for the sample being accepted.
	always_comb begin
		result.stable_buttons = deb_next;
		result.relay_out      = relay_next;
		result.toggled_relays = lanes_run ? toggles : '0;
		result.report_changed = report;
		result.read_error     = ~in_beat.read_ok;
	end

	// Mask state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounced_q <= '0;
			reported_q  <= '0;
			relay_q     <= LANE_MASK;
			snapshot_q  <= 1'b0;
		end else begin
			debounced_q <= deb_next;
			relay_q     <= relay_next;
			if (first) begin
				reported_q <= raw_masked;
				snapshot_q <= 1'b1;
			end else if (report) begin
				reported_q <= deb_next;
			end
		end
	end

endmodule

// ----- sv/button_debounce_relay_toggle_top.sv -----
// -----------------------------------------------------------------------------
// Button debounce and relay toggle, top level
// Debounces a sampled button bank and toggles a relay per button press.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one sample beat: the raw
//   button levels and a read-ok flag. Output channel out_valid/out_stall/
//   out_data carries one result beat per sample: debounced mask, relay mask,
//   toggled bits, a change-report flag and a read-error flag.
//   Each accepted result is registered at the output. Throughput is one beat
//   per cycle while out_stall is low; every button has its own counter lane,
//   all lanes update in the same cycle, and lane compare and mask merge are
//   combinational. When the receiver stalls, one more beat is taken into a
//   skid register; in_stall then rises until the held result is taken.
//   Reset clears the counters, the debounced and reported masks, sets all
//   lane relay bits to one, and restores the threshold to 3 and the
//   active-low polarity. The user must write the configuration port (cfg_we,
//   cfg_index, cfg_data) only while the block is idle; this is not enforced.
// -----------------------------------------------------------------------------
module button_debounce_relay_toggle_top #(
	parameter int NUM_BUTTONS = bdrt_pkg::NUM_BUTTONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bdrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdrt_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bdrt_pkg::in_beat_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bdrt_pkg::out_beat_t             out_data
);
	import bdrt_pkg::*;

	localparam int LANES = lane_count(NUM_BUTTONS);

	logic [CNT_W-1:0] threshold_q;
	logic             active_low_q;

	logic             accept;
	logic             lanes_run;
	lane_ctrl_t       ctrl;
	logic [BTN_W-1:0] raw_masked;
	logic [BTN_W-1:0] stable_mask;
	logic [BTN_W-1:0] flips;
	logic [BTN_W-1:0] toggles;
	out_beat_t        result;

	out_beat_t        out_q;
	logic             out_valid_q;
	out_beat_t        skid_q;
	logic             skid_valid_q;
	logic             out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RST;
			active_low_q <= ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_THRESHOLD:  threshold_q  <= cfg_data[CNT_W-1:0];
				CFG_ACTIVE_LOW: active_low_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Handshake and lane control.
	assign in_stall        = skid_valid_q;
	assign accept          = in_valid & ~in_stall;
	assign ctrl.update     = lanes_run;
	assign ctrl.threshold  = threshold_q;
	assign ctrl.active_low = active_low_q;

	// One debounce lane per button that reaches a port bit.
	for (genvar i = 0; i < BTN_W; i++) begin : g_lane
		if (i < LANES) begin : g_on
			bdrt_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.raw_bit    (raw_masked[i]),
				.stable_bit (stable_mask[i]),
				.flip       (flips[i]),
				.toggle     (toggles[i])
			);
		end else begin : g_off
			assign flips[i]   = 1'b0;
			assign toggles[i] = 1'b0;
		end
	end

	// Merge the lane findings into the masks.
	bdrt_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_beat     (in_data),
		.flips       (flips),
		.toggles     (toggles),
		.lanes_run   (lanes_run),
		.raw_masked  (raw_masked),
		.stable_mask (stable_mask),
		.result      (result)
	);

	// Output register with a skid stage behind it.
	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
